@@ rtl/biq_pkg.sv @@
// Package for the biquad IIR filter: default widths, register indexes,
// coefficient reset values and the control word of the shared MAC.
// No dependencies.
package biq_pkg;

  localparam int SAMPLE_WIDTH_DEF = 16;
  localparam int COEF_FRAC_DEF    = 16;
  localparam int DELAY_WIDTH      = 40;
  localparam int CFG_IDX_W        = 3;

  // Coefficient register indexes; codes 5..7 select nothing.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_B0 = 3'd0,
    REG_B1 = 3'd1,
    REG_B2 = 3'd2,
    REG_A1 = 3'd3,
    REG_A2 = 3'd4
  } reg_idx_t;

  // Butterworth low-pass, fc at 0.1 fs, Q2.16
  localparam int COEF_B0_RST = 4424;
  localparam int COEF_B1_RST = 8841;
  localparam int COEF_B2_RST = 4424;
  localparam int COEF_A1_RST = -74908;
  localparam int COEF_A2_RST = 27053;

  typedef struct packed {
    logic mul_en;  // load product register
    logic acc_en;  // load accumulator from adder
    logic sub;     // adder subtracts the product
  } biq_mac_ctrl_t;

endpackage

@@ rtl/biq_if.sv @@
// Stream interfaces of the biquad filter: input samples and filtered results.
// Valid/ready handshake; depends on nothing.
interface biq_in_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_in;

  modport source (output valid, output sample_in, input ready);
  modport sink   (input valid, input sample_in, output ready);
endinterface

interface biq_out_if #(parameter int SAMPLE_WIDTH = 16);
  logic                           valid;
  logic                           ready;
  logic signed [SAMPLE_WIDTH-1:0] sample_out;
  logic                           clipped;

  modport source (output valid, output sample_out, output clipped, input ready);
  modport sink   (input valid, input sample_out, input clipped, output ready);
endinterface

@@ rtl/biq_mac.sv @@
// Shared multiply-accumulate unit of the biquad: one registered signed
// multiplier followed by one add/subtract stage. Uses biq_pkg.
module biq_mac import biq_pkg::*; #(
  parameter int SW = SAMPLE_WIDTH_DEF,
  parameter int CW = COEF_FRAC_DEF + 2,
  parameter int AW = DELAY_WIDTH + 2
) (
  input  logic                 clk,
  input  biq_mac_ctrl_t        ctrl,
  input  logic signed [CW-1:0] coef,
  input  logic signed [SW-1:0] smp,
  input  logic signed [AW-1:0] add_a,
  output logic signed [AW-1:0] sum,
  output logic signed [AW-1:0] acc_r
);

  localparam int PW = SW + CW;

  logic signed [PW-1:0] prod_r;
  logic signed [AW-1:0] prod_ext;

  assign prod_ext = {{(AW-PW){prod_r[PW-1]}}, prod_r};
  assign sum      = ctrl.sub ? (add_a - prod_ext) : (add_a + prod_ext);

  always_ff @(posedge clk) begin
    if (ctrl.mul_en) begin
      prod_r <= coef * smp;
    end
    if (ctrl.acc_en) begin
      acc_r <= sum;
    end
  end

endmodule

@@ rtl/biquad_iir_filter.sv @@
// Biquad IIR section, transposed direct form II, on one shared multiplier.
// The five products run in turn through the single multiplier of biq_mac, so
// a new sample is taken only once the last result is in the output register.
// Synchronous active-low reset: coefficients to the low-pass defaults, delay
// terms to zero, no result pending, input ready.
module biquad_iir_filter import biq_pkg::*; #(
  parameter int SAMPLE_WIDTH   = SAMPLE_WIDTH_DEF,
  parameter int COEF_FRAC_BITS = COEF_FRAC_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  biq_in_if.sink                      in_s,
  biq_out_if.source                   out_s,
  input  logic                        cfg_we,
  input  logic [CFG_IDX_W-1:0]        cfg_idx,
  input  logic [COEF_FRAC_BITS+1:0]   cfg_data
);

  localparam int SW = SAMPLE_WIDTH;
  localparam int CW = COEF_FRAC_BITS + 2;
  localparam int DW = DELAY_WIDTH;
  localparam int PW = SW + CW;
  localparam int AW = ((PW > DW) ? PW : DW) + 2;
  localparam int YW = AW - COEF_FRAC_BITS;

  typedef enum logic [2:0] {
    S_IDLE, S_Y, S_N1A, S_N1B, S_N2A, S_N2B, S_PUSH
  } state_t;

  state_t state_r;

  logic signed [CW-1:0] b0_r, b1_r, b2_r, a1_r, a2_r;
  logic signed [DW-1:0] d1_r, d2_r;
  logic signed [SW-1:0] x_r, y_r;
  logic                 hit_r;
  logic                 out_valid_r;
  logic signed [SW-1:0] sample_out_r;
  logic                 clipped_r;

  biq_mac_ctrl_t        ctrl;
  logic signed [CW-1:0] coef;
  logic signed [SW-1:0] smp;
  logic signed [AW-1:0] add_a;
  logic signed [AW-1:0] sum;
  logic signed [AW-1:0] acc_r;

  logic                 in_xfer;
  logic                 out_free;
  logic signed [YW-1:0] shifted;
  logic                 y_ovf;
  logic signed [SW-1:0] y_sat;
  logic                 d_ovf;
  logic signed [DW-1:0] d_sat;

  assign in_s.ready       = (state_r == S_IDLE);
  assign in_xfer          = in_s.valid && in_s.ready;
  assign out_free         = !out_valid_r || out_s.ready;
  assign out_s.valid      = out_valid_r;
  assign out_s.sample_out = sample_out_r;
  assign out_s.clipped    = clipped_r;

  // Operand selection for the shared unit
  always_comb begin
    ctrl  = '0;
    coef  = b0_r;
    smp   = x_r;
    add_a = acc_r;
    unique case (state_r)
      S_IDLE: begin
        ctrl.mul_en = in_xfer;
        smp         = in_s.sample_in;
      end
      S_Y: begin
        ctrl.mul_en = 1'b1;
        coef        = b1_r;
        add_a       = {{(AW-DW){d1_r[DW-1]}}, d1_r};
      end
      S_N1A: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_en = 1'b1;
        coef        = a1_r;
        smp         = y_r;
        add_a       = {{(AW-DW){d2_r[DW-1]}}, d2_r};
      end
      S_N1B: begin
        ctrl.mul_en = 1'b1;
        ctrl.sub    = 1'b1;
        coef        = b2_r;
      end
      S_N2A: begin
        ctrl.mul_en = 1'b1;
        ctrl.acc_en = 1'b1;
        coef        = a2_r;
        smp         = y_r;
        add_a       = '0;
      end
      S_N2B: begin
        ctrl.sub = 1'b1;
      end
      S_PUSH: begin
      end
      default: begin
      end
    endcase
  end

  biq_mac #(
    .SW (SW),
    .CW (CW),
    .AW (AW)
  ) u_mac (
    .clk   (clk),
    .ctrl  (ctrl),
    .coef  (coef),
    .smp   (smp),
    .add_a (add_a),
    .sum   (sum),
    .acc_r (acc_r)
  );

  // Output: floor shift then clamp to the sample range
  assign shifted = sum[AW-1:COEF_FRAC_BITS];
  assign y_ovf   = (shifted[YW-1:SW-1] != {(YW-SW+1){shifted[YW-1]}});
  assign y_sat   = !y_ovf ? shifted[SW-1:0] :
                   shifted[YW-1] ? {1'b1, {(SW-1){1'b0}}} : {1'b0, {(SW-1){1'b1}}};

  // Delay update clamp to 40 bits
  assign d_ovf = (sum[AW-1:DW-1] != {(AW-DW+1){sum[AW-1]}});
  assign d_sat = !d_ovf ? sum[DW-1:0] :
                 sum[AW-1] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      b0_r        <= CW'(COEF_B0_RST);
      b1_r        <= CW'(COEF_B1_RST);
      b2_r        <= CW'(COEF_B2_RST);
      a1_r        <= CW'(COEF_A1_RST);
      a2_r        <= CW'(COEF_A2_RST);
      d1_r        <= '0;
      d2_r        <= '0;
    end else begin
      if (cfg_we) begin
        unique case (reg_idx_t'(cfg_idx))
          REG_B0:  b0_r <= cfg_data;
          REG_B1:  b1_r <= cfg_data;
          REG_B2:  b2_r <= cfg_data;
          REG_A1:  a1_r <= cfg_data;
          REG_A2:  a2_r <= cfg_data;
          default: ;
        endcase
      end

      // a new result loaded in the same cycle keeps the register full
      if (out_valid_r && out_s.ready &&
          !((state_r == S_N2B || state_r == S_PUSH) && out_free)) begin
        out_valid_r <= 1'b0;
      end

      unique case (state_r)
        S_IDLE: begin
          if (in_xfer) begin
            x_r     <= in_s.sample_in;
            state_r <= S_Y;
          end
        end
        S_Y: begin
          y_r     <= y_sat;
          hit_r   <= y_ovf;
          state_r <= S_N1A;
        end
        S_N1A: begin
          state_r <= S_N1B;
        end
        S_N1B: begin
          d1_r    <= d_sat;
          hit_r   <= hit_r | d_ovf;
          state_r <= S_N2A;
        end
        S_N2A: begin
          state_r <= S_N2B;
        end
        S_N2B: begin
          d2_r  <= d_sat;
          hit_r <= hit_r | d_ovf;
          if (out_free) begin
            out_valid_r  <= 1'b1;
            sample_out_r <= y_r;
            clipped_r    <= hit_r | d_ovf;
            state_r      <= S_IDLE;
          end else begin
            state_r <= S_PUSH;
          end
        end
        S_PUSH: begin
          // result waits here until the output register frees up
          if (out_free) begin
            out_valid_r  <= 1'b1;
            sample_out_r <= y_r;
            clipped_r    <= hit_r;
            state_r      <= S_IDLE;
          end
        end
        default: begin
          state_r <= S_IDLE;
        end
      endcase
    end
  end

endmodule

@@ rtl/biq_checker.sv @@
// Port-level checks for biquad_iir_filter, attached by bind.
// Depends on biquad_iir_filter and the biq_in_if / biq_out_if interfaces.
module biq_checker #(
  parameter int SAMPLE_WIDTH = 16
) (
  input logic                    clk,
  input logic                    rst_n,
  input logic                    in_valid,
  input logic                    in_ready,
  input logic                    out_valid,
  input logic                    out_ready,
  input logic [SAMPLE_WIDTH-1:0] sample_out,
  input logic                    clipped
);

  // The input stays not ready after each transfer while that sample is worked on
  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready ##1 !in_ready ##1 !in_ready
                               ##1 !in_ready ##1 !in_ready)
    else $error("input taken while a sample is still being worked on");

  // Out of reset nothing is pending and the input is open
  a_reset_state: assert property (@(posedge clk)
    $past(!rst_n) |-> (!out_valid && in_ready))
    else $error("bad state after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> out_valid)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> ($stable(sample_out) && $stable(clipped)))
    else $error("stalled result changed");

endmodule

bind biquad_iir_filter biq_checker #(
  .SAMPLE_WIDTH (SAMPLE_WIDTH)
) u_biq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_valid   (in_s.valid),
  .in_ready   (in_s.ready),
  .out_valid  (out_s.valid),
  .out_ready  (out_s.ready),
  .sample_out (out_s.sample_out),
  .clipped    (out_s.clipped)
);

@@ sim/biquad_iir_filter_test.sv @@
// Self-checking bench for biquad_iir_filter: random samples and coefficient sets
// against an in-bench fixed-point model of the transposed direct form II section.
// Depends on rtl/biq_pkg.sv, rtl/biq_if.sv and rtl/biquad_iir_filter.sv.
`timescale 1ns / 100ps

module biquad_iir_filter_test;
  import biq_pkg::*;

  localparam int SW       = SAMPLE_WIDTH_DEF;
  localparam int FRAC     = COEF_FRAC_DEF;
  localparam int CW       = FRAC + 2;
  localparam int COEF_MAX = 2 ** (CW - 1) - 1;
  localparam int COEF_MIN = -(2 ** (CW - 1));
  localparam int UNITY    = 2 ** FRAC;
  localparam int MAX_GAP  = 8;
  localparam int LATENCY  = 6;
  localparam int CYCLE_LIMIT = 300000;
  localparam int PHASE_LEN   = 145;

  // register codes that select nothing
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_LO = 3'd5;
  localparam logic [CFG_IDX_W-1:0] IDX_UNUSED_HI = 3'd7;

  typedef struct {
    logic signed [SW-1:0] y;
    logic                 clip;
  } filt_res_t;

  logic                 clk;
  logic                 rst_n;
  logic                 cfg_we;
  logic [CFG_IDX_W-1:0] cfg_idx;
  logic [CW-1:0]        cfg_data;

  biq_in_if  #(.SAMPLE_WIDTH(SW)) in_ch ();
  biq_out_if #(.SAMPLE_WIDTH(SW)) out_ch ();

  biquad_iir_filter #(
    .SAMPLE_WIDTH  (SW),
    .COEF_FRAC_BITS(FRAC)
  ) i_dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_s    (in_ch),
    .out_s   (out_ch),
    .cfg_we  (cfg_we),
    .cfg_idx (cfg_idx),
    .cfg_data(cfg_data)
  );

  // model state
  logic signed [CW-1:0]          coef_regs [5];
  logic signed [DELAY_WIDTH-1:0] d1_model, d2_model;

  filt_res_t pending_out[$];
  int        err_cnt, samples_sent, results_seen, clips_seen, cfg_writes, cycle_cnt;
  bit        no_gaps;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt >= CYCLE_LIMIT) begin
      $display("%0t: timeout, %0d results still outstanding", $time, pending_out.size());
      $display("*** FAILED ***");
      $finish;
    end
  end

  function automatic longint clamp_to(input longint v, input int w, inout bit hit);
    longint hi, lo;
    hi = (longint'(1) << (w - 1)) - 1;
    lo = -hi - 1;
    if (v > hi) begin
      hit = 1'b1;
      return hi;
    end
    if (v < lo) begin
      hit = 1'b1;
      return lo;
    end
    return v;
  endfunction

  // one step of the section: output from b0*x + d1, then both delay updates
  function automatic filt_res_t tdf2_update(input logic signed [SW-1:0] x);
    filt_res_t r;
    bit        hit;
    longint    xv, yv, acc, n1, n2;
    hit = 1'b0;
    xv  = x;
    acc = longint'(coef_regs[REG_B0]) * xv + longint'(d1_model);
    yv  = clamp_to(acc >>> FRAC, SW, hit);
    n1  = longint'(coef_regs[REG_B1]) * xv - longint'(coef_regs[REG_A1]) * yv
          + longint'(d2_model);
    n2  = longint'(coef_regs[REG_B2]) * xv - longint'(coef_regs[REG_A2]) * yv;
    d1_model = DELAY_WIDTH'(clamp_to(n1, DELAY_WIDTH, hit));
    d2_model = DELAY_WIDTH'(clamp_to(n2, DELAY_WIDTH, hit));
    r.y    = SW'(yv);
    r.clip = hit;
    return r;
  endfunction

  function automatic int draw_gap();
    if (no_gaps) return 0;
    return $urandom_range(0, MAX_GAP);
  endfunction

  function automatic logic signed [SW-1:0] random_sample();
    case ($urandom_range(0, 9))
      0: return $urandom_range(0, 1) ? {1'b0, {(SW-1){1'b1}}} : {1'b1, {(SW-1){1'b0}}};
      1, 2: return SW'($signed($urandom_range(0, 511)) - 256);
      default: return SW'($urandom());
    endcase
  endfunction

  task automatic cfg_write(input logic [CFG_IDX_W-1:0] idx, input logic [CW-1:0] val);
    @(negedge clk);
    cfg_we   <= 1'b1;
    cfg_idx  <= idx;
    cfg_data <= val;
    @(posedge clk);
    if (idx <= REG_A2) coef_regs[idx] = val;
    cfg_writes++;
  endtask

  task automatic cfg_release();
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  task automatic load_coefs(input int b0, input int b1, input int b2, input int a1,
                            input int a2);
    cfg_write(REG_B0, CW'(b0));
    cfg_write(REG_B1, CW'(b1));
    cfg_write(REG_B2, CW'(b2));
    cfg_write(REG_A1, CW'(a1));
    cfg_write(REG_A2, CW'(a2));
    cfg_release();
  endtask

  task automatic send_sample(input logic signed [SW-1:0] x);
    int gap;
    gap = draw_gap();
    @(negedge clk);
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.sample_in <= x;
    do @(posedge clk); while (in_ch.ready !== 1'b1);
    pending_out.push_back(tdf2_update(x));
    samples_sent++;
  endtask

  task automatic stop_sending();
    @(negedge clk);
    in_ch.valid <= 1'b0;
  endtask

  // the block is idle once every result is back and the pipeline has had time to empty
  task automatic wait_drained();
    stop_sending();
    while (pending_out.size() != 0) @(posedge clk);
    repeat (LATENCY + 2) @(posedge clk);
  endtask

  // result sink: random stall before each transfer
  initial begin
    int stall;
    out_ch.ready = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      stall = draw_gap();
      @(negedge clk);
      if (stall > 0) begin
        out_ch.ready <= 1'b0;
        repeat (stall) @(negedge clk);
      end
      out_ch.ready <= 1'b1;
      do @(posedge clk); while (!(out_ch.valid === 1'b1 && out_ch.ready === 1'b1));
    end
  end

  always @(posedge clk) begin
    filt_res_t exp_r;
    if (rst_n && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      results_seen++;
      if (pending_out.size() == 0) begin
        $display("%0t: result %0d/%0b with nothing expected", $time,
                 out_ch.sample_out, out_ch.clipped);
        err_cnt++;
      end else begin
        exp_r = pending_out.pop_front();
        if (exp_r.clip) clips_seen++;
        if (out_ch.sample_out !== exp_r.y) begin
          $display("%0t: sample_out expected %0d actual %0d", $time, exp_r.y,
                   out_ch.sample_out);
          err_cnt++;
        end
        if (out_ch.clipped !== exp_r.clip) begin
          $display("%0t: clipped expected %0b actual %0b", $time, exp_r.clip,
                   out_ch.clipped);
          err_cnt++;
        end
      end
    end
  end

  task automatic test_reset_response();
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample('0);
    send_sample(SW'(1));
    send_sample('1);
    send_sample(16'sh5555);
    send_sample(16'shAAAA);
    wait_drained();
  endtask

  // large gains with unstable feedback push the output into both clamps
  task automatic test_output_clamp();
    load_coefs(COEF_MAX, COEF_MIN, COEF_MAX, COEF_MIN, COEF_MAX);
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample('0);
    send_sample('0);
    wait_drained();
  endtask

  // pass-through set-up, then writes to codes that select nothing must not disturb it
  task automatic test_unused_index();
    load_coefs(UNITY, 0, 0, 0, 0);
    for (int i = IDX_UNUSED_LO; i <= IDX_UNUSED_HI; i++)
      cfg_write(CFG_IDX_W'(i), CW'($urandom()));
    cfg_release();
    send_sample(16'sh1234);
    send_sample({1'b1, {(SW-1){1'b0}}});
    send_sample({1'b0, {(SW-1){1'b1}}});
    send_sample('1);
    send_sample(16'sh0F0F);
    wait_drained();
  endtask

  task automatic run_phase(input int b0, input int b1, input int b2, input int a1,
                           input int a2);
    load_coefs(b0, b1, b2, a1, a2);
    for (int i = 0; i < PHASE_LEN; i++) begin
      if (i % 48 == 0) no_gaps = ($urandom_range(0, 3) == 0);
      send_sample(random_sample());
    end
    no_gaps = 1'b0;
    wait_drained();
  endtask

  // delay saturation cannot be reached with 18-bit coefficients and 16-bit samples;
  // the model still clamps the delay terms
  task automatic test_random_phases();
    run_phase(COEF_B0_RST, COEF_B1_RST, COEF_B2_RST, COEF_A1_RST, COEF_A2_RST);
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_phase(COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX, COEF_MAX);
    run_phase(COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN, COEF_MIN);
    run_phase($urandom_range(0, 2 * UNITY) - UNITY, $urandom_range(0, 2 * UNITY) - UNITY,
              $urandom_range(0, 2 * UNITY) - UNITY, $urandom_range(0, 2 * UNITY) - UNITY,
              $urandom_range(0, UNITY / 2));
    run_phase($urandom(), $urandom(), $urandom(), $urandom(), $urandom());
    run_phase(COEF_MAX, 0, COEF_MIN, COEF_MIN, COEF_MAX);
  endtask

  initial begin
    clk             = 1'b0;
    rst_n           = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = '0;
    cfg_data        = '0;
    in_ch.valid     = 1'b0;
    in_ch.sample_in = '0;
    no_gaps         = 1'b0;
    coef_regs[REG_B0] = CW'(COEF_B0_RST);
    coef_regs[REG_B1] = CW'(COEF_B1_RST);
    coef_regs[REG_B2] = CW'(COEF_B2_RST);
    coef_regs[REG_A1] = CW'(COEF_A1_RST);
    coef_regs[REG_A2] = CW'(COEF_A2_RST);
    d1_model = '0;
    d2_model = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_reset_response();
    test_output_clamp();
    test_unused_index();
    test_random_phases();

    repeat (LATENCY * 3) @(posedge clk);
    $display("Sent %0d samples over %0d coefficient writes; %0d results checked.",
             samples_sent, cfg_writes, results_seen);
    $display("%0d results flagged as clipped, %0d mismatches.", clips_seen, err_cnt);
    if (err_cnt == 0 && pending_out.size() == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
